@@ src/mtsiu_pkg.sv @@
package mtsiu_pkg;

  // number of harts served by the window
  localparam int HARTS = 4;

  // visible interrupt lanes in the result item
  localparam int IRQ_LANES = 4;

  // window layout, byte offsets
  localparam logic [15:0] SOFT_BASE = 16'h0000;
  localparam logic [15:0] CMP_BASE  = 16'h4000;
  localparam logic [15:0] TIME_BASE = 16'hBFF8;

  // bytes per register
  localparam int SOFT_BYTES = 4;
  localparam int CMP_BYTES  = 8;
  localparam int TIME_BYTES = 8;

  // largest access in bytes
  localparam logic [3:0] MAX_SIZE = 4'd8;

  // operation codes
  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] offset;
    logic [3:0]  access_size;
    logic [63:0] write_data;
    logic [31:0] tick_count;
  } in_item_t;

  typedef struct packed {
    logic [63:0]          read_data;
    logic [IRQ_LANES-1:0] timer_irq;
    logic [IRQ_LANES-1:0] soft_irq;
  } out_item_t;

endpackage

@@ src/machine_timer_software_irq_unit_core.sv @@
// each item passes the input register, then the result register
// throughput: one item per cycle unless stalled; single pass between the two registers
// a stalled result register holds further items in the input register
// reset (rst, synchronous): both stages empty, software words, compare values,
// time counter and timer-pending flags all cleared to zero
module machine_timer_software_irq_unit_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mtsiu_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mtsiu_pkg::out_item_t out_item
);

  // input stage
  logic                item_valid;
  mtsiu_pkg::in_item_t item;
  logic                advance;

  // architectural state
  logic [31:0]                 soft_words     [mtsiu_pkg::HARTS];
  logic [63:0]                 compare_values [mtsiu_pkg::HARTS];
  logic [63:0]                 time_counter;
  logic [mtsiu_pkg::HARTS-1:0] timer_pending;

  // next state and result
  logic [31:0]                 soft_words_next     [mtsiu_pkg::HARTS];
  logic [63:0]                 compare_values_next [mtsiu_pkg::HARTS];
  logic [63:0]                 time_counter_next;
  logic [mtsiu_pkg::HARTS-1:0] timer_pending_next;
  mtsiu_pkg::out_item_t        result;

  // handshake: the input stage moves whenever its item can enter the result register
  assign advance  = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || advance;

  // byte selection: is window byte at addr inside the access, and which lane
  function automatic logic byte_hit(input logic [15:0] addr, input logic [15:0] base,
                                    input logic [3:0] size);
    logic [15:0] diff;
    diff = addr - base;
    return (addr >= base) && (diff < 16'(size));
  endfunction

  function automatic logic [2:0] byte_lane(input logic [15:0] addr, input logic [15:0] base);
    logic [15:0] diff;
    diff = addr - base;
    return diff[2:0];
  endfunction

  // single pass: byte merge for writes, byte gather for reads, tick add, compares
  always_comb begin
    logic [3:0]  size_sat;
    logic [15:0] addr;
    logic        hit;
    logic [2:0]  lane;
    logic [63:0] rdata;
    logic        is_write;
    logic        is_read;

    size_sat = (item.access_size > mtsiu_pkg::MAX_SIZE) ? mtsiu_pkg::MAX_SIZE
                                                        : item.access_size;
    is_write = (item.mode == mtsiu_pkg::MODE_WRITE);
    is_read  = (item.mode == mtsiu_pkg::MODE_READ);
    rdata    = '0;

    // software words
    for (int h = 0; h < mtsiu_pkg::HARTS; h++) begin
      soft_words_next[h] = soft_words[h];
      for (int b = 0; b < mtsiu_pkg::SOFT_BYTES; b++) begin
        addr = mtsiu_pkg::SOFT_BASE + 16'(h * mtsiu_pkg::SOFT_BYTES + b);
        hit  = byte_hit(addr, item.offset, size_sat);
        lane = byte_lane(addr, item.offset);
        if (hit) begin
          rdata = rdata | (64'(soft_words[h][b*8 +: 8]) << {lane, 3'b000});
          if (is_write) begin
            soft_words_next[h][b*8 +: 8] = item.write_data[{lane, 3'b000} +: 8];
          end
        end
      end
    end

    // compare values
    for (int h = 0; h < mtsiu_pkg::HARTS; h++) begin
      compare_values_next[h] = compare_values[h];
      for (int b = 0; b < mtsiu_pkg::CMP_BYTES; b++) begin
        addr = mtsiu_pkg::CMP_BASE + 16'(h * mtsiu_pkg::CMP_BYTES + b);
        hit  = byte_hit(addr, item.offset, size_sat);
        lane = byte_lane(addr, item.offset);
        if (hit) begin
          rdata = rdata | (64'(compare_values[h][b*8 +: 8]) << {lane, 3'b000});
          if (is_write) begin
            compare_values_next[h][b*8 +: 8] = item.write_data[{lane, 3'b000} +: 8];
          end
        end
      end
    end

    // time counter: tick adds, write merges bytes
    if (item.mode == mtsiu_pkg::MODE_TICK) begin
      time_counter_next = time_counter + 64'(item.tick_count);
    end else begin
      time_counter_next = time_counter;
    end
    for (int b = 0; b < mtsiu_pkg::TIME_BYTES; b++) begin
      addr = mtsiu_pkg::TIME_BASE + 16'(b);
      hit  = byte_hit(addr, item.offset, size_sat);
      lane = byte_lane(addr, item.offset);
      if (hit) begin
        rdata = rdata | (64'(time_counter[b*8 +: 8]) << {lane, 3'b000});
        if (is_write) begin
          time_counter_next[b*8 +: 8] = item.write_data[{lane, 3'b000} +: 8];
        end
      end
    end

    // timer-pending flags refresh after writes and ticks only
    for (int h = 0; h < mtsiu_pkg::HARTS; h++) begin
      if (is_write || (item.mode == mtsiu_pkg::MODE_TICK)) begin
        timer_pending_next[h] = (time_counter_next >= compare_values_next[h]);
      end else begin
        timer_pending_next[h] = timer_pending[h];
      end
    end

    // result item
    result.read_data = is_read ? rdata : '0;
    result.timer_irq = '0;
    result.soft_irq  = '0;
    for (int h = 0; h < mtsiu_pkg::IRQ_LANES; h++) begin
      if (h < mtsiu_pkg::HARTS) begin
        result.timer_irq[h] = timer_pending_next[h];
        result.soft_irq[h]  = (soft_words_next[h] != 32'd0);
      end
    end
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid    <= 1'b0;
      out_valid     <= 1'b0;
      time_counter  <= '0;
      timer_pending <= '0;
      for (int h = 0; h < mtsiu_pkg::HARTS; h++) begin
        soft_words[h]     <= '0;
        compare_values[h] <= '0;
      end
    end else begin
      if (in_ready) begin
        item_valid <= in_valid;
      end
      if (advance) begin
        out_valid     <= 1'b1;
        time_counter  <= time_counter_next;
        timer_pending <= timer_pending_next;
        for (int h = 0; h < mtsiu_pkg::HARTS; h++) begin
          soft_words[h]     <= soft_words_next[h];
          compare_values[h] <= compare_values_next[h];
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
    if (advance) begin
      out_item <= result;
    end
  end

endmodule
